### hdl/float_matrix_multiply_unit_defines.svh
// Assertion macros shared by the matrix multiply RTL.
`ifndef FLOAT_MATRIX_MULTIPLY_UNIT_DEFINES_SVH
`define FLOAT_MATRIX_MULTIPLY_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during rst.
`define FMM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fmm assertion failed");

// Next-cycle implication, clocked on clk, off during rst.
`define FMM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fmm assertion failed");

`endif

### hdl/fmm_pkg.sv
// Package: widths and constants of the float matrix multiply unit.
`timescale 1ns / 1ps
package fmm_pkg;
  localparam int MAX_K = 256;
  localparam int MAX_N = 64;
  localparam int K_W = $clog2(MAX_K);
  localparam int N_W = $clog2(MAX_N);
  localparam int BSTORE_DEPTH = MAX_K * MAX_N;
  localparam int FLT_W = 32;
  localparam int ROW_W = 16;
  localparam logic [FLT_W-1:0] CANON_NAN = 32'h7FC0_0000;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_INNER_K   = 2'd0,
    REG_COLS_N    = 2'd1,
    REG_ROW_COUNT = 2'd2
  } cfg_reg_t;

  // item commands
  typedef enum logic {
    CMD_B_WRITE = 1'b0,
    CMD_A_ELEM  = 1'b1
  } item_cmd_t;
endpackage

### hdl/fmm_if.sv
// Interfaces: input item channel and result channel.
`timescale 1ns / 1ps
interface fmm_item_if;
  import fmm_pkg::*;
  logic             valid;
  logic             ready;
  logic             cmd;
  logic [FLT_W-1:0] elem_value;
  logic [K_W-1:0]   k_index;
  logic [N_W-1:0]   col_index;
  modport source (output valid, cmd, elem_value, k_index, col_index, input ready);
  modport sink (input valid, cmd, elem_value, k_index, col_index, output ready);
endinterface

interface fmm_result_if;
  import fmm_pkg::*;
  logic             valid;
  logic             ready;
  logic [FLT_W-1:0] result_value;
  logic [N_W-1:0]   result_col;
  logic [ROW_W-1:0] result_row;
  logic             last_in_row;
  logic             last_of_matrix;
  modport source (output valid, result_value, result_col, result_row, last_in_row,
                  last_of_matrix, input ready);
  modport sink (input valid, result_value, result_col, result_row, last_in_row,
                last_of_matrix, output ready);
endinterface

### hdl/float_matrix_multiply_unit.sv
// Top level: single precision C = A x B with B stationary, one shared rounding unit.
//
//  channel  | dir | payload                                         | transfer when
//  ---------+-----+-------------------------------------------------+---------------
//  item     | in  | cmd, elem_value, k_index, col_index             | valid & ready
//  result   | out | result_value, result_col, result_row, last_*    | valid & ready
//  cfg      | in  | cfg_index (0 inner_k, 1 cols_n, 2 row_count)    | cfg_we
//
//  A B write (cmd 0) is stored on the item transfer. An A element runs each column in use
//  through read, mantissa multiply, product round, align/add and sum round, with the one
//  shared rounding unit doing both rounds; the last element of a row adds, per result,
//  an accumulator read and an output hold, plus any result stall.
//  item.ready is high only in idle. rst is synchronous and clears control state;
//  the B store is not cleared, accumulators read as +0 until written after a k=0 item.
`timescale 1ns / 1ps
`include "float_matrix_multiply_unit_defines.svh"
module float_matrix_multiply_unit (
  input  logic                      clk,
  input  logic                      rst,
  fmm_item_if.sink                  item,
  fmm_result_if.source              result,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [fmm_pkg::ROW_W-1:0] cfg_data
);
  import fmm_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_MRND = 3'd3;
  localparam logic [2:0] S_ADD  = 3'd4;
  localparam logic [2:0] S_ARND = 3'd5;
  localparam logic [2:0] S_ORD  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  // Round a nonnegative 48-bit magnitude scaled by 2^ex to single precision, RNE.
  function automatic logic [31:0] round_pack(input logic sgn, input logic signed [11:0] ex,
                                             input logic [47:0] mant);
    logic [5:0]         lz;
    logic               found;
    logic [47:0]        nrm;
    logic [47:0]        shr;
    logic signed [12:0] be;
    logic signed [12:0] dd;
    logic [5:0]         sh;
    logic [7:0]         ebf;
    logic               stk;
    logic               up;
    logic [23:0]        m;
    logic [30:0]        mag;
    lz = '0;
    found = 1'b0;
    for (int i = 47; i >= 0; i--) begin
      if (!found && mant[i]) begin
        lz = 6'(47 - i);
        found = 1'b1;
      end
    end
    nrm = mant << lz;
    be = $signed({ex[11], ex}) - $signed({7'd0, lz}) + 13'sd174;
    dd = 13'sd1 - be;
    if (be < 13'sd1) begin
      sh = (dd > 13'sd47) ? 6'd48 : 6'(dd);
      ebf = 8'd1;
    end else begin
      sh = '0;
      ebf = be[7:0];
    end
    shr = nrm >> sh;
    stk = |(nrm & ~({48{1'b1}} << sh));
    m = shr[47:24];
    up = shr[23] & (|shr[22:0] | stk | m[0]);
    mag = {ebf - 8'd1, 23'd0} + {7'd0, m} + 31'(up);
    if (mant == '0) return {sgn, 31'd0};
    if (be >= 13'sd255) return {sgn, 8'hFF, 23'd0};
    return {sgn, mag};
  endfunction

  // configuration
  logic [8:0]       inner_k;
  logic [6:0]       cols_n;
  logic [ROW_W-1:0] row_count;
  logic [8:0]       kk;
  logic [6:0]       nn;
  logic [ROW_W-1:0] rows_eff;

  // sequencer
  logic [2:0]       state;
  logic [FLT_W-1:0] a_val;
  logic [K_W-1:0]   k_cur;
  logic [N_W-1:0]   col_cnt;
  logic             do_emit;
  logic [ROW_W-1:0] row_counter;
  logic             last_col;
  logic             last_row;

  // storage
  logic [FLT_W-1:0] b_mem [BSTORE_DEPTH];
  logic [FLT_W-1:0] acc_mem [MAX_N];
  logic [MAX_N-1:0] acc_vld;
  logic [FLT_W-1:0] b_rd;
  logic [FLT_W-1:0] acc_rd;
  logic             accv_rd;
  logic [FLT_W-1:0] acc_op;

  // multiply stage registers
  logic [47:0]        mp_prod;
  logic signed [11:0] mp_exp;
  logic               mp_sgn;
  logic               mp_nan;
  logic               mp_inf;
  logic [FLT_W-1:0]   prod;

  // add stage registers
  logic [47:0]        ad_sum;
  logic signed [11:0] ad_exp;
  logic               ad_sgn;
  logic               ad_nan;
  logic               ad_inf;
  logic               ad_isg;

  // shared rounding unit
  logic               rp_sgn;
  logic signed [11:0] rp_exp;
  logic [47:0]        rp_mant;
  logic [FLT_W-1:0]   rp_out;

  logic item_fire;
  logic res_fire;

  assign item_fire = item.valid && item.ready;
  assign res_fire  = result.valid && result.ready;

  // clamped sizes
  always_comb begin
    kk = (inner_k == '0) ? 9'd1 : (inner_k > 9'(MAX_K)) ? 9'(MAX_K) : inner_k;
    nn = (cols_n == '0) ? 7'd1 : (cols_n > 7'(MAX_N)) ? 7'(MAX_N) : cols_n;
    rows_eff = (row_count == '0) ? 16'd1 : row_count;
  end

  assign last_col = ({1'b0, col_cnt} == nn - 7'd1);
  assign last_row = (row_counter >= rows_eff - 16'd1);
  assign acc_op   = accv_rd ? acc_rd : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      inner_k   <= 9'd256;
      cols_n    <= 7'd64;
      row_count <= 16'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INNER_K:   inner_k <= cfg_data[8:0];
        REG_COLS_N:    cols_n <= cfg_data[6:0];
        REG_ROW_COUNT: row_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // memories: B store written by cmd 0, accumulators written after sum rounding
  always_ff @(posedge clk) begin
    if (item_fire && (item.cmd == CMD_B_WRITE)) begin
      b_mem[{item.k_index, item.col_index}] <= item.elem_value;
    end
    b_rd <= b_mem[{k_cur, col_cnt}];
  end

  always_ff @(posedge clk) begin
    if (state == S_ARND) begin
      acc_mem[col_cnt] <= rp_out;
    end
    acc_rd <= acc_mem[col_cnt];
  end

  // shared rounding unit input select
  always_comb begin
    if (state == S_MRND) begin
      rp_sgn = mp_sgn;
      rp_exp = mp_exp;
      rp_mant = mp_prod;
    end else begin
      rp_sgn = ad_sgn;
      rp_exp = ad_exp;
      rp_mant = ad_sum;
    end
    rp_out = round_pack(rp_sgn, rp_exp, rp_mant);
    if (state == S_MRND) begin
      if (mp_nan) rp_out = CANON_NAN;
      else if (mp_inf) rp_out = {mp_sgn, 8'hFF, 23'd0};
    end else begin
      if (ad_nan) rp_out = CANON_NAN;
      else if (ad_inf) rp_out = {ad_isg, 8'hFF, 23'd0};
    end
  end

  // multiply datapath: unpack and 24x24 mantissa product
  logic [7:0]  ma_e;
  logic [7:0]  mb_e;
  logic [23:0] ma_m;
  logic [23:0] mb_m;
  logic        a_nan, a_inf, a_zero, b_nan, b_inf, b_zero;

  always_comb begin
    a_nan  = (a_val[30:23] == 8'hFF) && (a_val[22:0] != '0);
    a_inf  = (a_val[30:23] == 8'hFF) && (a_val[22:0] == '0);
    a_zero = (a_val[30:0] == '0);
    b_nan  = (b_rd[30:23] == 8'hFF) && (b_rd[22:0] != '0);
    b_inf  = (b_rd[30:23] == 8'hFF) && (b_rd[22:0] == '0);
    b_zero = (b_rd[30:0] == '0);
    ma_e = (a_val[30:23] == '0) ? 8'd1 : a_val[30:23];
    mb_e = (b_rd[30:23] == '0) ? 8'd1 : b_rd[30:23];
    ma_m = {a_val[30:23] != '0, a_val[22:0]};
    mb_m = {b_rd[30:23] != '0, b_rd[22:0]};
  end

  // add datapath: order by magnitude, align with jammed sticky, add or subtract
  logic [FLT_W-1:0] big;
  logic [FLT_W-1:0] sml;
  logic [7:0]       e1;
  logic [7:0]       e2;
  logic [7:0]       ed;
  logic [5:0]       dcl;
  logic [47:0]      m1;
  logic [47:0]      m2f;
  logic [47:0]      m2;
  logic [47:0]      sum;
  logic             x_nan, x_inf, y_nan, y_inf;

  always_comb begin
    x_nan = (acc_op[30:23] == 8'hFF) && (acc_op[22:0] != '0);
    x_inf = (acc_op[30:23] == 8'hFF) && (acc_op[22:0] == '0);
    y_nan = (prod[30:23] == 8'hFF) && (prod[22:0] != '0);
    y_inf = (prod[30:23] == 8'hFF) && (prod[22:0] == '0);
    if (prod[30:0] > acc_op[30:0]) begin
      big = prod;
      sml = acc_op;
    end else begin
      big = acc_op;
      sml = prod;
    end
    e1 = (big[30:23] == '0) ? 8'd1 : big[30:23];
    e2 = (sml[30:23] == '0) ? 8'd1 : sml[30:23];
    ed = e1 - e2;
    dcl = (ed > 8'd47) ? 6'd48 : ed[5:0];
    m1 = {1'b0, big[30:23] != '0, big[22:0], 23'd0};
    m2f = {1'b0, sml[30:23] != '0, sml[22:0], 23'd0};
    m2 = (m2f >> dcl) | 48'(|(m2f & ~({48{1'b1}} << dcl)));
    sum = (big[31] == sml[31]) ? (m1 + m2) : (m1 - m2);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      col_cnt     <= '0;
      row_counter <= '0;
      acc_vld     <= '0;
      do_emit     <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (item_fire && (item.cmd == CMD_A_ELEM)) begin
            if (item.k_index == '0) acc_vld <= '0;
            if ({1'b0, item.k_index} < kk) begin
              k_cur   <= item.k_index;
              col_cnt <= '0;
              do_emit <= ({1'b0, item.k_index} == kk - 9'd1);
              state   <= S_RD;
            end
          end
        end
        S_RD:   state <= S_MUL;
        S_MUL:  state <= S_MRND;
        S_MRND: state <= S_ADD;
        S_ADD:  state <= S_ARND;
        S_ARND: begin
          acc_vld[col_cnt] <= 1'b1;
          if (last_col) begin
            col_cnt <= '0;
            state   <= do_emit ? S_ORD : S_IDLE;
          end else begin
            col_cnt <= col_cnt + 1'b1;
            state   <= S_RD;
          end
        end
        S_ORD: state <= S_OUT;
        S_OUT: begin
          if (result.ready) begin
            if (last_col) begin
              row_counter <= last_row ? '0 : row_counter + 1'b1;
              state       <= S_IDLE;
            end else begin
              col_cnt <= col_cnt + 1'b1;
              state   <= S_ORD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk) begin
    if (item_fire && (item.cmd == CMD_A_ELEM)) a_val <= item.elem_value;
    accv_rd <= acc_vld[col_cnt];
    if (state == S_MUL) begin
      mp_prod <= ma_m * mb_m;
      mp_exp  <= $signed({4'd0, ma_e}) + $signed({4'd0, mb_e}) - 12'sd300;
      mp_sgn  <= a_val[31] ^ b_rd[31];
      mp_nan  <= a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero);
      mp_inf  <= a_inf || b_inf;
    end
    if (state == S_MRND) prod <= rp_out;
    if (state == S_ADD) begin
      ad_sum <= sum;
      ad_exp <= $signed({4'd0, e1}) - 12'sd173;
      ad_sgn <= (sum == '0) ? (acc_op[31] & prod[31]) : big[31];
      ad_nan <= x_nan || y_nan || (x_inf && y_inf && (acc_op[31] != prod[31]));
      ad_inf <= x_inf || y_inf;
      ad_isg <= x_inf ? acc_op[31] : prod[31];
    end
  end

  assign item.ready            = (state == S_IDLE);
  assign result.valid          = (state == S_OUT);
  assign result.result_value   = acc_op;
  assign result.result_col     = col_cnt;
  assign result.result_row     = row_counter;
  assign result.last_in_row    = last_col;
  assign result.last_of_matrix = last_col && last_row;

  `FMM_ASSERT_NEXT(a_clear_at_k0,
                   item_fire && (item.cmd == CMD_A_ELEM) && (item.k_index == '0),
                   acc_vld == '0)
  `FMM_ASSERT_NOW(a_out_col_in_range, result.valid, {1'b0, col_cnt} <= nn - 7'd1)
  `FMM_ASSERT_NOW(a_matrix_end_is_row_end, result.valid && result.last_of_matrix,
                  result.last_in_row)
  `FMM_ASSERT_NEXT(a_row_done_idle, res_fire && result.last_in_row, item.ready)
endmodule
